### hw/rtl/scl3_pkg.sv
// Shared types and constants of the Scale3x upscaler.
// Used by scl3_block_seq and scale3x_pixel_art_upscale; depends on nothing.
package scl3_pkg;

  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 11;
  localparam int unsigned CoordW           = 10;
  localparam int unsigned PortColorW       = 32;
  localparam int unsigned NumBlk           = 4;
  localparam int unsigned ResetFrameWidth  = 320;
  localparam int unsigned ResetFrameHeight = 200;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } scl3_cfg_reg_e;

  typedef logic [CoordW-1:0] coord_t;

  // One item's worth of block work handed to the sequencer. Mask bits in
  // emission order: previous column upper row, previous column last row,
  // current column upper row, current column last row.
  typedef struct packed {
    logic [NumBlk-1:0] blk_mask;
    logic              row_first;
    logic              row_second;
    coord_t            col_a;
    coord_t            col_b;
    coord_t            row_prev;
    coord_t            row_cur;
  } scl3_job_t;

endpackage

### hw/rtl/scl3_row_ram.sv
// Single-port-write, single-port-read row store with registered read data.
// Read returns the old contents when read and write hit the same entry.
module scl3_row_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/scl3_block_seq.sv
// Block sequencer: holds one item's window snapshot and emits its Scale3x
// blocks into the output register, one per cycle while the output is not stalled. Depends on scl3_pkg.
module scl3_block_seq #(
  parameter int unsigned ColorBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  scl3_pkg::scl3_job_t           job_i,
  input  logic [8:0][ColorBits-1:0]     win_i,
  output logic                          job_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output scl3_pkg::coord_t              block_x_o,
  output scl3_pkg::coord_t              block_y_o,
  output logic [8:0][ColorBits-1:0]     px_o,
  output logic                          last_o
);
  import scl3_pkg::*;

  typedef logic [8:0][ColorBits-1:0] blk_t;
  typedef logic [2:0][ColorBits-1:0] row_t;

  function automatic blk_t scale3x(input logic [ColorBits-1:0] a, input logic [ColorBits-1:0] b,
                                   input logic [ColorBits-1:0] c, input logic [ColorBits-1:0] d,
                                   input logic [ColorBits-1:0] e, input logic [ColorBits-1:0] f,
                                   input logic [ColorBits-1:0] g, input logic [ColorBits-1:0] h,
                                   input logic [ColorBits-1:0] i);
    blk_t px;
    for (int k = 0; k < 9; k++) begin
      px[k] = e;
    end
    if (b != h && d != f) begin
      px[0] = (d == b) ? d : e;
      px[1] = ((d == b && e != c) || (b == f && e != a)) ? b : e;
      px[2] = (b == f) ? f : e;
      px[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
      px[5] = ((b == f && e != i) || (h == f && e != c)) ? f : e;
      px[6] = (d == h) ? d : e;
      px[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
      px[8] = (h == f) ? f : e;
    end
    return px;
  endfunction

  logic              job_valid_q;
  scl3_job_t         job_q;
  blk_t              win_q;
  logic              out_valid_q;
  coord_t            bx_q;
  coord_t            by_q;
  blk_t              px_q;
  logic              last_q;

  logic [1:0]        sel;
  logic              use_col_b;
  logic              use_last_row;
  logic [NumBlk-1:0] mask_clr;
  logic              is_last;
  logic              out_load;
  row_t [2:0]        rowv;
  row_t              top_row;
  row_t              mid_row;
  row_t              bot_row;
  blk_t              blk;

  always_comb begin
    if (job_q.blk_mask[0]) begin
      sel = 2'd0;
    end else if (job_q.blk_mask[1]) begin
      sel = 2'd1;
    end else if (job_q.blk_mask[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    use_col_b    = sel[1];
    use_last_row = sel[0];
    mask_clr     = job_q.blk_mask & ~(NumBlk'(1) << sel);
    is_last      = (mask_clr == '0);

    // The column beyond the right edge repeats the last column (edge clamp).
    for (int rr = 0; rr < 3; rr++) begin
      rowv[rr][0] = use_col_b ? win_q[rr*3+1] : win_q[rr*3+0];
      rowv[rr][1] = use_col_b ? win_q[rr*3+2] : win_q[rr*3+1];
      rowv[rr][2] = win_q[rr*3+2];
    end

    if (use_last_row) begin
      top_row = job_q.row_first ? rowv[2] : rowv[1];
      mid_row = rowv[2];
    end else begin
      top_row = job_q.row_second ? rowv[1] : rowv[0];
      mid_row = rowv[1];
    end
    bot_row = rowv[2];

    blk = scale3x(top_row[0], top_row[1], top_row[2],
                  mid_row[0], mid_row[1], mid_row[2],
                  bot_row[0], bot_row[1], bot_row[2]);
  end

  assign out_load    = !out_valid_q || out_ready_i;
  assign job_ready_o = !job_valid_q || (out_load && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        job_valid_q <= 1'b1;
      end else if (job_valid_q && out_load && is_last) begin
        job_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= job_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
      win_q <= win_i;
    end else if (job_valid_q && out_load) begin
      job_q.blk_mask <= mask_clr;
    end
    if (job_valid_q && out_load) begin
      bx_q   <= use_col_b ? job_q.col_b : job_q.col_a;
      by_q   <= use_last_row ? job_q.row_cur : job_q.row_prev;
      px_q   <= blk;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_x_o   = bx_q;
  assign block_y_o   = by_q;
  assign px_o        = px_q;
  assign last_o      = last_q;

  a_job_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_q.blk_mask != '0)
    else $error("sequencer holds a job with no blocks left");

  a_no_empty_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |-> job_i.blk_mask != '0)
    else $error("job loaded without any block to emit");

  a_advance_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && out_load |=> out_valid_q)
    else $error("sequencer advanced but no block was presented");

endmodule

### hw/rtl/scale3x_pixel_art_upscale.sv
// Scale3x upscaler top level: counters, row stores, window and sequencer.
// Depends on scl3_pkg, scl3_row_ram and scl3_block_seq.
// Path: item stage, then the sequencer's job register, then its output register.
// Throughput: one item per cycle while each causes at most one block and out_ready_i is high;
// a multi-block item holds the sequencer until its last block loads, which slows the last row.
// Reset: counters and window zero, frame 320 x 200; row stores are not cleared.
module scale3x_pixel_art_upscale #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned COLOR_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scl3_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [scl3_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [scl3_pkg::PortColorW-1:0]     pixel_color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [scl3_pkg::CoordW-1:0]         block_x_o,
  output logic [scl3_pkg::CoordW-1:0]         block_y_o,
  output logic [scl3_pkg::PortColorW-1:0]     top_left_o,
  output logic [scl3_pkg::PortColorW-1:0]     top_mid_o,
  output logic [scl3_pkg::PortColorW-1:0]     top_right_o,
  output logic [scl3_pkg::PortColorW-1:0]     mid_left_o,
  output logic [scl3_pkg::PortColorW-1:0]     center_o,
  output logic [scl3_pkg::PortColorW-1:0]     mid_right_o,
  output logic [scl3_pkg::PortColorW-1:0]     bottom_left_o,
  output logic [scl3_pkg::PortColorW-1:0]     bottom_mid_o,
  output logic [scl3_pkg::PortColorW-1:0]     bottom_right_o,
  output logic                                last_of_run_o
);
  import scl3_pkg::*;

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned DimWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RstW  = (ResetFrameWidth > MAX_WIDTH) ? MAX_WIDTH : ResetFrameWidth;
  localparam int unsigned RstH  = (ResetFrameHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetFrameHeight;

  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic [8:0][COLOR_BITS-1:0] win_t;

  // Configuration and position.
  logic [DimWW-1:0] fw_q, fw_d;
  logic [DimHW-1:0] fh_q, fh_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [31:0]      cfg_val;
  logic             cfg_hit;

  // Item stage waiting on the row store read data.
  logic             p1_valid_q;
  color_t           p1_pix_q;
  logic [ColW-1:0]  p1_col_q;
  logic             p1_col0_q;
  scl3_job_t        p1_job_q;
  scl3_job_t        job_d;
  logic             fwd_q;
  color_t           fwd_data_q;

  win_t             win_q;
  win_t             win_nx;

  logic             in_acc;
  logic             p1_fire;
  logic             job_ready;
  color_t           pix;
  color_t           older_rdata;
  color_t           recent_rdata;
  color_t           fa;
  logic             col_last;
  logic             row_last;
  win_t             px;

  assign cfg_ready_o = 1'b1;
  assign pix         = pixel_color_i[COLOR_BITS-1:0];
  assign in_acc      = in_valid_i && in_ready_o;
  assign p1_fire     = p1_valid_q && ((p1_job_q.blk_mask == '0) || job_ready);
  assign in_ready_o  = !p1_valid_q || p1_fire;

  // Frame size writes clamp to 1..MAX and restart the frame; other indices are ignored.
  always_comb begin
    cfg_val = 32'(cfg_data_i);
    cfg_hit = 1'b0;
    fw_d    = fw_q;
    fh_d    = fh_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_val == 32'd0) begin
            fw_d = DimWW'(1);
          end else if (cfg_val > 32'(MAX_WIDTH)) begin
            fw_d = DimWW'(MAX_WIDTH);
          end else begin
            fw_d = DimWW'(cfg_val);
          end
        end
        CFG_FRAME_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_val == 32'd0) begin
            fh_d = DimHW'(1);
          end else if (cfg_val > 32'(MAX_HEIGHT)) begin
            fh_d = DimHW'(MAX_HEIGHT);
          end else begin
            fh_d = DimHW'(cfg_val);
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    col_last = (DimWW'(col_q) + DimWW'(1)) >= fw_q;
    row_last = (DimHW'(row_q) + DimHW'(1)) >= fh_q;

    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end

    job_d.blk_mask[0] = (col_q != '0) && (row_q != '0);
    job_d.blk_mask[1] = (col_q != '0) && row_last;
    job_d.blk_mask[2] = col_last && (row_q != '0);
    job_d.blk_mask[3] = col_last && row_last;
    job_d.row_first   = (row_q == '0);
    job_d.row_second  = (row_q == RowW'(1));
    job_d.col_a       = CoordW'(col_q - ColW'(1));
    job_d.col_b       = CoordW'(col_q);
    job_d.row_prev    = CoordW'(row_q - RowW'(1));
    job_d.row_cur     = CoordW'(row_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= DimWW'(RstW);
      fh_q       <= DimHW'(RstH);
      col_q      <= '0;
      row_q      <= '0;
      p1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      fw_q  <= fw_d;
      fh_q  <= fh_d;
      col_q <= col_d;
      row_q <= row_d;
      if (in_ready_o) begin
        p1_valid_q <= in_valid_i;
      end
      // The older store is written when the item stage fires; an item read
      // at that same edge from the same entry sees stale data.
      if (in_acc) begin
        fwd_q <= p1_fire && (p1_col_q == col_q);
      end
      if (cfg_hit) begin
        win_q <= '0;
      end else if (p1_fire) begin
        win_q <= win_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_pix_q   <= pix;
      p1_col_q   <= col_q;
      p1_col0_q  <= (col_q == '0);
      p1_job_q   <= job_d;
      fwd_data_q <= recent_rdata;
    end
  end

  scl3_row_ram #(
    .Depth (MAX_WIDTH),
    .Width (COLOR_BITS),
    .AddrW (ColW)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (p1_fire),
    .waddr_i (p1_col_q),
    .wdata_i (recent_rdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (older_rdata)
  );

  scl3_row_ram #(
    .Depth (MAX_WIDTH),
    .Width (COLOR_BITS),
    .AddrW (ColW)
  ) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (pix),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (recent_rdata)
  );

  assign fa = fwd_q ? fwd_data_q : older_rdata;

  // Column zero fills the whole row of the window (left edge clamp).
  always_comb begin
    color_t v;
    for (int rr = 0; rr < 3; rr++) begin
      v = (rr == 0) ? fa : ((rr == 1) ? recent_rdata : p1_pix_q);
      if (p1_col0_q) begin
        win_nx[rr*3+0] = v;
        win_nx[rr*3+1] = v;
        win_nx[rr*3+2] = v;
      end else begin
        win_nx[rr*3+0] = win_q[rr*3+1];
        win_nx[rr*3+1] = win_q[rr*3+2];
        win_nx[rr*3+2] = v;
      end
    end
  end

  scl3_block_seq #(
    .ColorBits (COLOR_BITS)
  ) u_block_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (p1_fire && (p1_job_q.blk_mask != '0)),
    .job_i       (p1_job_q),
    .win_i       (win_nx),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .block_x_o   (block_x_o),
    .block_y_o   (block_y_o),
    .px_o        (px),
    .last_o      (last_of_run_o)
  );

  assign top_left_o     = PortColorW'(px[0]);
  assign top_mid_o      = PortColorW'(px[1]);
  assign top_right_o    = PortColorW'(px[2]);
  assign mid_left_o     = PortColorW'(px[3]);
  assign center_o       = PortColorW'(px[4]);
  assign mid_right_o    = PortColorW'(px[5]);
  assign bottom_left_o  = PortColorW'(px[6]);
  assign bottom_mid_o   = PortColorW'(px[7]);
  assign bottom_right_o = PortColorW'(px[8]);

  a_col_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimWW'(col_q) < fw_q)
    else $error("column counter outside the frame width");

  a_row_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimHW'(row_q) < fh_q)
    else $error("row counter outside the frame height");

  a_dims_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fw_q != '0 && fh_q != '0)
    else $error("frame dimension is zero");

  a_p1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && !p1_fire |=> p1_valid_q && $stable(p1_col_q))
    else $error("stalled item left the read stage");

endmodule

### tb/sv/tb_scale3x_pixel_art_upscale.sv
// Self-checking testbench for the Scale3x upscaler top level.
// Depends on scl3_pkg and scale3x_pixel_art_upscale; holds its own Scale3x predictor
// and checks every output block against it under random sender gaps and receiver stalls.
`timescale 1ns / 100ps

module tb_scale3x_pixel_art_upscale;
  import scl3_pkg::*;

  typedef logic [PortColorW-1:0]           color_t;
  typedef logic [CfgDataW-1:0]             cfg_word_t;
  typedef logic [2:0][PortColorW-1:0]      trio_t;   // [0] is the left column
  typedef logic [2:0][2:0][PortColorW-1:0] win_t;    // [row][col], rows older, recent, new

  typedef struct packed {
    coord_t                      bx;
    coord_t                      by;
    logic [8:0][PortColorW-1:0]  px;
    logic                        last_flag;
  } out_block_t;

  typedef enum int unsigned {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_e;

  localparam int unsigned               MaxWidth      = 1024;
  localparam int unsigned               MaxHeight     = 1024;
  localparam int unsigned               IdleSettle    = 8;
  localparam int unsigned               TimeoutNs     = 10_000_000;
  localparam logic [CfgIdxW-1:0]        CfgIdxUnused  = 2'd3;
  localparam color_t                    ColDark       = 32'h0000_0000;
  localparam color_t                    ColBright     = 32'hFFFF_FFFF;
  localparam color_t                    ColMid        = 32'h5A5A_A5A5;
  localparam color_t DiagFrame [9] = '{ColBright, ColBright, ColDark,
                                       ColBright, ColDark,   ColDark,
                                       ColDark,   ColDark,   ColDark};
  localparam color_t MixFrame [9]  = '{ColBright, ColDark,   ColMid,
                                       ColDark,   ColDark,   ColMid,
                                       ColMid,    ColMid,    ColBright};

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  cfg_word_t             cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  color_t                pixel_color_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  coord_t                block_x_o;
  coord_t                block_y_o;
  color_t                top_left_o, top_mid_o, top_right_o;
  color_t                mid_left_o, center_o, mid_right_o;
  color_t                bottom_left_o, bottom_mid_o, bottom_right_o;
  logic                  last_of_run_o;

  scale3x_pixel_art_upscale i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_color_i  (pixel_color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_x_o      (block_x_o),
    .block_y_o      (block_y_o),
    .top_left_o     (top_left_o),
    .top_mid_o      (top_mid_o),
    .top_right_o    (top_right_o),
    .mid_left_o     (mid_left_o),
    .center_o       (center_o),
    .mid_right_o    (mid_right_o),
    .bottom_left_o  (bottom_left_o),
    .bottom_mid_o   (bottom_mid_o),
    .bottom_right_o (bottom_right_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Predictor state: row stores, window, position and frame size.
  color_t       older_line  [MaxWidth];
  color_t       recent_line [MaxWidth];
  win_t         nbr_win      = '0;
  int unsigned  next_col     = 0;
  int unsigned  next_row     = 0;
  int unsigned  frame_w      = ResetFrameWidth;
  int unsigned  frame_h      = ResetFrameHeight;

  out_block_t   expected_blocks [$];
  out_block_t   step_blocks     [$];

  int unsigned  fail_count     = 0;
  int unsigned  pixels_sent    = 0;
  int unsigned  blocks_checked = 0;
  int unsigned  cfg_writes     = 0;
  bit           sender_idle    = 1'b0;
  int unsigned  burst_left     = 0;
  rx_mode_e     rx_mode        = RX_FREE;
  int unsigned  rx_left        = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d output blocks still expected.", expected_blocks.size());
    $display("== FAIL ==");
    $finish;
  end

  // Scale3x rule on one 3x3 neighborhood; pixel order is raster within the block.
  function automatic out_block_t scale3x_rule(coord_t bx, coord_t by,
                                              trio_t t, trio_t m, trio_t b);
    color_t     a, bb, c, d, e, f, g, h, i;
    out_block_t blk;
    a = t[0]; bb = t[1]; c = t[2];
    d = m[0]; e  = m[1]; f = m[2];
    g = b[0]; h  = b[1]; i = b[2];
    blk.bx        = bx;
    blk.by        = by;
    blk.last_flag = 1'b0;
    for (int k = 0; k < 9; k++) blk.px[k] = e;
    if (bb != h && d != f) begin
      blk.px[0] = (d == bb) ? d : e;
      blk.px[1] = ((d == bb && e != c) || (bb == f && e != a)) ? bb : e;
      blk.px[2] = (bb == f) ? f : e;
      blk.px[3] = ((d == bb && e != g) || (d == h && e != a)) ? d : e;
      blk.px[5] = ((bb == f && e != i) || (h == f && e != c)) ? f : e;
      blk.px[6] = (d == h) ? d : e;
      blk.px[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
      blk.px[8] = (h == f) ? f : e;
    end
    return blk;
  endfunction

  // Blocks for one column: the previous row, and the current row when it is the last one.
  // Rows beyond the frame border repeat the nearest row inside it.
  function automatic void column_blocks(int unsigned x, win_t w);
    if (next_row >= 1) begin
      step_blocks.push_back(scale3x_rule(coord_t'(x), coord_t'(next_row - 1),
                                         (next_row == 1) ? w[1] : w[0], w[1], w[2]));
    end
    if (next_row == frame_h - 1) begin
      step_blocks.push_back(scale3x_rule(coord_t'(x), coord_t'(next_row),
                                         (next_row == 0) ? w[2] : w[1], w[2], w[2]));
    end
  endfunction

  function automatic void predict_pixel(color_t pix);
    int unsigned c;
    color_t      fa, fb, v;
    win_t        edge_win;
    out_block_t  blk;
    c = (next_col >= frame_w) ? 0 : next_col;
    fa = older_line[c];
    fb = recent_line[c];
    older_line[c]  = fb;
    recent_line[c] = pix;
    for (int r = 0; r < 3; r++) begin
      v = (r == 0) ? fa : (r == 1) ? fb : pix;
      if (c == 0) begin
        nbr_win[r] = {v, v, v};
      end else begin
        nbr_win[r] = {v, nbr_win[r][2], nbr_win[r][1]};
      end
    end
    step_blocks.delete();
    if (c >= 1) column_blocks(c - 1, nbr_win);
    if (c == frame_w - 1) begin
      // Right border: the column beyond the edge repeats the last column.
      for (int r = 0; r < 3; r++) edge_win[r] = {nbr_win[r][2], nbr_win[r][2], nbr_win[r][1]};
      column_blocks(c, edge_win);
    end
    for (int k = 0; k < step_blocks.size(); k++) begin
      blk = step_blocks[k];
      blk.last_flag = (k == step_blocks.size() - 1);
      expected_blocks.push_back(blk);
    end
    if (c + 1 >= frame_w) begin
      next_col = 0;
      next_row = (next_row + 1 >= frame_h) ? 0 : next_row + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function automatic int unsigned clamp_size(cfg_word_t value, int unsigned bound);
    if (value == 0) return 1;
    if (value > bound) return bound;
    return 32'(value);
  endfunction

  // Waits until every expected block has left, then lets in-flight items settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, cfg_word_t value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
      if (idx == CFG_FRAME_WIDTH) frame_w = clamp_size(value, MaxWidth);
      else frame_h = clamp_size(value, MaxHeight);
      next_col = 0;
      next_row = 0;
      nbr_win  = '0;
    end
  endtask

  // Sends one pixel item; returns after its accepting edge, or after a sender gap behind it.
  task automatic send_pixel(color_t color);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    pixel_color_i <= color;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(color);
    pixels_sent++;
    if (sender_idle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Pixels mostly from a small palette, so that neighbors often match.
  task automatic send_run(int unsigned count, trio_t palette, int unsigned noise_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < noise_pct) send_pixel($urandom);
      else send_pixel(palette[$urandom_range(0, 2)]);
    end
  endtask

  function automatic trio_t random_palette();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Receiver: ready follows a random pattern mode, redrawn when its random hold runs out.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(10, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:     out_ready_i <= 1'b1;
      RX_SPARSE:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ready_i <= ((rx_left % 8) >= 3);
      default:     out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  out_block_t got_blk, want_blk;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_blk.bx        = block_x_o;
      got_blk.by        = block_y_o;
      got_blk.px        = {bottom_right_o, bottom_mid_o, bottom_left_o,
                           mid_right_o, center_o, mid_left_o,
                           top_right_o, top_mid_o, top_left_o};
      got_blk.last_flag = last_of_run_o;
      blocks_checked++;
      if (expected_blocks.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: unexpected block x=%0d y=%0d at %0t", got_blk.bx, got_blk.by, $time);
        end
      end else begin
        want_blk = expected_blocks.pop_front();
        if (got_blk.bx !== want_blk.bx || got_blk.by !== want_blk.by ||
            got_blk.px !== want_blk.px || got_blk.last_flag !== want_blk.last_flag) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: block mismatch at %0t", $time);
            $display("  expected x=%0d y=%0d last=%0b px=%h", want_blk.bx, want_blk.by,
                     want_blk.last_flag, want_blk.px);
            $display("  actual   x=%0d y=%0d last=%0b px=%h", got_blk.bx, got_blk.by,
                     got_blk.last_flag, got_blk.px);
          end
        end
      end
    end
  end

  // The frame out of reset is 320 x 200: the start of the first row causes no blocks.
  task automatic test_reset_frame();
    sender_idle = 1'b1;
    send_run(40, random_palette(), 20);
  endtask

  task automatic test_corner_frames();
    sender_idle = 1'b0;
    // Zero in both registers means a 1x1 frame.
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    send_pixel(ColDark);
    send_pixel(ColBright);
    // 2x2: the last pixel of the frame closes four blocks at once.
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(2));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(2));
    send_pixel(ColDark);
    send_pixel(ColBright);
    send_pixel(ColBright);
    send_pixel(ColDark);
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(3));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(3));
    for (int k = 0; k < 9; k++) send_pixel(DiagFrame[k]);
    for (int k = 0; k < 9; k++) send_pixel(MixFrame[k]);
  endtask

  // Values above the bound saturate; the start of a full-width row and of a full-height column.
  task automatic test_size_limits();
    sender_idle = 1'b1;
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(1));
    send_run(16, random_palette(), 10);
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(1));
    write_reg(CFG_FRAME_HEIGHT, '1);
    send_run(16, random_palette(), 10);
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(MaxHeight));
    send_run(16, random_palette(), 10);
  endtask

  // A write in the middle of a frame restarts it; an unused index changes nothing.
  task automatic test_frame_restart();
    trio_t palette;
    palette = random_palette();
    sender_idle = 1'b1;
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(5));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(4));
    send_run(7, palette, 10);
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(4));
    send_run(20, palette, 10);
    write_reg(CfgIdxUnused, cfg_word_t'(11'h555));
    send_run(20, palette, 10);
  endtask

  task automatic test_random_frames();
    int unsigned target, w, h, count;
    target = pixels_sent + 150;
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(4));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(3));
    while (pixels_sent < target) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      h = (w > 9) ? $urandom_range(1, 3) : $urandom_range(1, 7);
      sender_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_FRAME_WIDTH, cfg_word_t'(w));
        1: write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(h));
        2: begin
          write_reg(CFG_FRAME_WIDTH, cfg_word_t'(w));
          write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(h));
        end
        default: ;
      endcase
      count = frame_w * frame_h;
      if (count > 40) count = 40;
      // Now and then a frame is cut short and the next write restarts it.
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      send_run(count, random_palette(), 15);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_frame();
    test_corner_frames();
    test_size_limits();
    test_frame_restart();
    test_random_frames();
    wait_idle();
    $display("Sent %0d pixels under %0d register writes, frames from 1x1 to 1024 wide",
             pixels_sent, cfg_writes);
    $display("and 1024 tall; checked %0d output blocks, %0d failures.",
             blocks_checked, fail_count);
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
